FILE: hw/rtl/axis_angle_vector_rotation_assert.svh
// Assertion macros for the vector rotation RTL.
`ifndef AXIS_ANGLE_VECTOR_ROTATION_ASSERT_SVH
`define AXIS_ANGLE_VECTOR_ROTATION_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define AAVR_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define AAVR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hw/rtl/aavr_pkg.sv
// Package with widths, CORDIC constants and rounding helpers for the rotation block.
`default_nettype none
package aavr_pkg;
    localparam int COMP_WIDTH   = 16;
    localparam int FRAC_BITS    = 12;
    localparam int ANGLE_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TRIG_W       = 16;
    localparam int CR_W         = COMP_WIDTH + 2;
    localparam int ACC_W        = 48;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE = 16'sd16384;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef logic signed [COMP_WIDTH-1:0] comp_t;
    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [CR_W-1:0] cr_t;
    typedef logic signed [33:0] cw_t;
    typedef logic signed [32:0] cz_t;

    function automatic cz_t atan_turn(input int i);
        logic [31:0] t;
        begin
            case (i)
                0: t = 32'h20000000;  1: t = 32'h12E4051D;
                2: t = 32'h09FB385B;  3: t = 32'h051111D4;
                4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
                6: t = 32'h00A2F61E;  7: t = 32'h00517C55;
                8: t = 32'h0028BE53;  9: t = 32'h00145F2F;
                10: t = 32'h000A2F98; 11: t = 32'h000517CC;
                12: t = 32'h00028BE6; 13: t = 32'h000145F3;
                14: t = 32'h0000A2F9; 15: t = 32'h0000517C;
                default: t = 32'h0;
            endcase
            atan_turn = $signed({1'b0, t});
        end
    endfunction

    // Product of two components rounded half up to FRAC_BITS fraction bits.
    function automatic logic signed [2*COMP_WIDTH-FRAC_BITS:0] rprod(
        input logic signed [2*COMP_WIDTH-1:0] p);
        logic signed [2*COMP_WIDTH:0] t;
        begin
            t = {p[2*COMP_WIDTH-1], p} + (33'sd1 <<< (FRAC_BITS - 1));
            rprod = t[2*COMP_WIDTH:FRAC_BITS];
        end
    endfunction

    // Saturate to +-(2^COMP_WIDTH - 1).
    function automatic cr_t sat_lim(input logic signed [2*COMP_WIDTH-FRAC_BITS+2:0] x,
                                     output logic hit);
        logic signed [2*COMP_WIDTH-FRAC_BITS+2:0] lim;
        begin
            lim = (1 <<< COMP_WIDTH) - 1;
            hit = 1'b0;
            if (x > lim) begin
                hit = 1'b1;
                sat_lim = cr_t'(lim);
            end else if (x < -lim) begin
                hit = 1'b1;
                sat_lim = cr_t'(-lim);
            end else begin
                sat_lim = cr_t'(x);
            end
        end
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/axis_angle_vector_rotation.sv
// Top level of the pipelined axis-angle vector rotation block.
// This block rotates a vector about a unit axis by a binary angle with the
// Rodrigues formula and returns one result request for every input request.
// It accepts a new request in every cycle while the result side does not stall;
// a result reaches m_tvalid through the 16-step CORDIC pipeline plus its input
// and rounding stages and the three-stage output accumulation. The whole
// pipeline advances only when its last stage is empty or being taken, so a
// stall on the result side freezes every stage and nothing is lost.
// The clipped flag rides in m_tuser and reports saturation in the geometry terms and the output rounding.
`default_nettype none
module axis_angle_vector_rotation (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // vec_x[15:0], vec_y[31:16], vec_z[47:32], axis_x[63:48], axis_y[79:64],
    // axis_z[95:80], turn_angle[111:96]
    input  wire logic [111:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // rot_x[15:0], rot_y[31:16], rot_z[47:32]
    output logic [47:0]       m_tdata,
    // clipped[0]
    output logic              m_tuser
);
    // CORDIC: 1 input + 16 steps + 1 rounding = 18; accumulation 3 more.
    localparam int LAT = aavr_pkg::CORDIC_STEPS + 5;
    // Exact product widths of the three accumulation terms.
    localparam int PA_W = aavr_pkg::COMP_WIDTH + aavr_pkg::TRIG_W;
    localparam int PB_W = aavr_pkg::CR_W + aavr_pkg::TRIG_W;
    localparam int PC_W = aavr_pkg::CR_W + aavr_pkg::TRIG_W + 1;

    logic en;
    logic [LAT-1:0] vld_reg;
    aavr_pkg::trig_t c_w, s_w;
    aavr_pkg::comp_t v_w [3];
    aavr_pkg::cr_t cr_w [3], w_w [3];
    logic clip_w;

    // The pipe moves when the output is empty or being taken.
    assign en = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    aavr_cordic u_cordic (
        .aclk(aclk), .en(en), .angle(s_tdata[111:96]),
        .cos_out(c_w), .sin_out(s_w)
    );

    aavr_geom u_geom (
        .aclk(aclk), .en(en),
        .vx(s_tdata[15:0]), .vy(s_tdata[31:16]), .vz(s_tdata[47:32]),
        .kx(s_tdata[63:48]), .ky(s_tdata[79:64]), .kz(s_tdata[95:80]),
        .v_out(v_w), .cr_out(cr_w), .w_out(w_w), .clip_out(clip_w)
    );

    // Three accumulation stages: products, sum, rounding with saturation.
    logic signed [aavr_pkg::ACC_W-1:0] pa_reg [3], pb_reg [3], pc_reg [3];
    logic signed [aavr_pkg::ACC_W-1:0] acc_reg [3];
    logic clip_a_reg, clip_b_reg, clip_o_reg;
    aavr_pkg::comp_t rot_reg [3];
    // One minus cosine spans 0 to 2.0, so it needs one bit more than the cosine.
    logic signed [aavr_pkg::TRIG_W:0] omc_w;
    aavr_pkg::comp_t rot_next [3];
    logic hit_next [3];

    assign omc_w = (aavr_pkg::TRIG_W+1)'(aavr_pkg::TRIG_ONE) - (aavr_pkg::TRIG_W+1)'(c_w);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [aavr_pkg::ACC_W-1:0] t;
            logic signed [aavr_pkg::ACC_W-15:0] r;
            t = acc_reg[i] + 48'sd8192;
            r = t[aavr_pkg::ACC_W-1:14];
            hit_next[i] = 1'b0;
            if (r > 34'sd32767) begin
                rot_next[i] = 16'sh7fff;
                hit_next[i] = 1'b1;
            end else if (r < -34'sd32768) begin
                rot_next[i] = 16'sh8000;
                hit_next[i] = 1'b1;
            end else begin
                rot_next[i] = aavr_pkg::comp_t'(r);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pa_reg[i] <= aavr_pkg::ACC_W'(PA_W'(v_w[i]) * PA_W'(c_w));
                pb_reg[i] <= aavr_pkg::ACC_W'(PB_W'(cr_w[i]) * PB_W'(s_w));
                pc_reg[i] <= aavr_pkg::ACC_W'(PC_W'(w_w[i]) * PC_W'(omc_w));
                acc_reg[i] <= pa_reg[i] + pb_reg[i] + pc_reg[i];
                rot_reg[i] <= rot_next[i];
            end
            clip_a_reg <= clip_w;
            clip_b_reg <= clip_a_reg;
            clip_o_reg <= clip_b_reg | hit_next[0] | hit_next[1] | hit_next[2];
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata = {rot_reg[2], rot_reg[1], rot_reg[0]};
    assign m_tuser = clip_o_reg;

`include "axis_angle_vector_rotation_assert.svh"
    `AAVR_ASSERT_IMP(a_stall_blocks, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    `AAVR_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `AAVR_ASSERT_NEXT(a_pipe_moves, aclk, aresetn, s_tready && s_tvalid, vld_reg[0])
endmodule
`default_nettype wire

FILE: hw/rtl/aavr_cordic.sv
// Pipelined CORDIC that turns a binary angle into Q1.14 cosine and sine.
`default_nettype none
module aavr_cordic (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic [aavr_pkg::ANGLE_WIDTH-1:0]   angle,
    output aavr_pkg::trig_t                          cos_out,
    output aavr_pkg::trig_t                          sin_out
);
    localparam int N = aavr_pkg::CORDIC_STEPS;
    aavr_pkg::cw_t x_reg [N+1];
    aavr_pkg::cw_t y_reg [N+1];
    aavr_pkg::cz_t z_reg [N+1];
    logic          flip_reg [N+1];
    aavr_pkg::trig_t cos_reg, sin_reg;

    logic [31:0] a_full;
    logic [31:0] a_fold;
    logic        q_flip;

    always_comb begin
        a_full = {angle, {(32-aavr_pkg::ANGLE_WIDTH){1'b0}}};
        q_flip = (a_full[31:30] == 2'd1) || (a_full[31:30] == 2'd2);
        a_fold = q_flip ? a_full - 32'h80000000 : a_full;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= aavr_pkg::CORDIC_X0;
            y_reg[0]    <= '0;
            z_reg[0]    <= $signed({a_fold[31], a_fold});
            flip_reg[0] <= q_flip;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][32]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - aavr_pkg::atan_turn(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + aavr_pkg::atan_turn(i);
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    function automatic aavr_pkg::trig_t round_clamp(input aavr_pkg::cw_t v, input logic f);
        logic signed [34:0] t;
        logic signed [18:0] r;
        logic signed [18:0] c;
        begin
            t = {v[33], v} + 35'sd32768;
            r = t[34:16];
            if (r > 19'sd16384) c = 19'sd16384;
            else if (r < -19'sd16384) c = -19'sd16384;
            else c = r;
            if (f) c = -c;
            round_clamp = aavr_pkg::trig_t'(c);
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= round_clamp(x_reg[N], flip_reg[N]);
            sin_reg <= round_clamp(y_reg[N], flip_reg[N]);
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/aavr_geom.sv
// Cross, dot and projection terms of the rotation, pipelined in step with the CORDIC.
`default_nettype none
module aavr_geom (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire aavr_pkg::comp_t vx, vy, vz, kx, ky, kz,
    output aavr_pkg::comp_t      v_out [3],
    output aavr_pkg::cr_t        cr_out [3],
    output aavr_pkg::cr_t        w_out [3],
    output logic                 clip_out
);
    localparam int PW = 2*aavr_pkg::COMP_WIDTH;
    localparam int RW = 2*aavr_pkg::COMP_WIDTH - aavr_pkg::FRAC_BITS + 1;
    localparam int SW = RW + 2;
    localparam int DLY = aavr_pkg::CORDIC_STEPS + 2 - 4;

    aavr_pkg::comp_t v1_reg [3], k1_reg [3];
    logic signed [PW-1:0] p_reg [9];
    aavr_pkg::comp_t v2_reg [3], k2_reg [3];
    aavr_pkg::cr_t cr3_reg [3], dot3_reg;
    logic clip3_reg;
    aavr_pkg::comp_t v3_reg [3], k3_reg [3];
    logic signed [PW+1:0] wp_reg [3];
    aavr_pkg::cr_t cr4_reg [3];
    logic clip4_reg;
    aavr_pkg::comp_t v4_reg [3];
    aavr_pkg::comp_t vd_reg [DLY][3];
    aavr_pkg::cr_t crd_reg [DLY][3], wd_reg [DLY][3];
    logic clipd_reg [DLY];

    logic signed [SW-1:0] c_sum [3];
    logic signed [SW-1:0] d_sum;
    aavr_pkg::cr_t c_sat [3], d_sat;
    logic c_hit [3];
    logic d_hit;
    aavr_pkg::cr_t w_sat [3];
    logic w_hit [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_sum[i] = SW'(aavr_pkg::rprod(p_reg[2*i])) - SW'(aavr_pkg::rprod(p_reg[2*i+1]));
            c_sat[i] = aavr_pkg::sat_lim(c_sum[i], c_hit[i]);
        end
        d_sum = SW'(aavr_pkg::rprod(p_reg[6])) + SW'(aavr_pkg::rprod(p_reg[7]))
              + SW'(aavr_pkg::rprod(p_reg[8]));
        d_sat = aavr_pkg::sat_lim(d_sum, d_hit);
        for (int i = 0; i < 3; i++) begin
            logic signed [PW+2:0] t;
            t = {wp_reg[i][PW+1], wp_reg[i]} + (1 <<< (aavr_pkg::FRAC_BITS - 1));
            w_sat[i] = aavr_pkg::sat_lim(SW'(t >>> aavr_pkg::FRAC_BITS), w_hit[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_reg <= '{vx, vy, vz};
            k1_reg <= '{kx, ky, kz};
            p_reg[0] <= PW'(k1_reg[1]) * PW'(v1_reg[2]);
            p_reg[1] <= PW'(k1_reg[2]) * PW'(v1_reg[1]);
            p_reg[2] <= PW'(k1_reg[2]) * PW'(v1_reg[0]);
            p_reg[3] <= PW'(k1_reg[0]) * PW'(v1_reg[2]);
            p_reg[4] <= PW'(k1_reg[0]) * PW'(v1_reg[1]);
            p_reg[5] <= PW'(k1_reg[1]) * PW'(v1_reg[0]);
            p_reg[6] <= PW'(k1_reg[0]) * PW'(v1_reg[0]);
            p_reg[7] <= PW'(k1_reg[1]) * PW'(v1_reg[1]);
            p_reg[8] <= PW'(k1_reg[2]) * PW'(v1_reg[2]);
            v2_reg <= v1_reg;
            k2_reg <= k1_reg;
            cr3_reg <= c_sat;
            dot3_reg <= d_sat;
            clip3_reg <= c_hit[0] | c_hit[1] | c_hit[2] | d_hit;
            v3_reg <= v2_reg;
            k3_reg <= k2_reg;
            for (int i = 0; i < 3; i++)
                wp_reg[i] <= (PW+2)'(k3_reg[i]) * (PW+2)'(dot3_reg);
            cr4_reg <= cr3_reg;
            clip4_reg <= clip3_reg;
            v4_reg <= v3_reg;
            vd_reg[0] <= v4_reg;
            crd_reg[0] <= cr4_reg;
            wd_reg[0] <= w_sat;
            clipd_reg[0] <= clip4_reg | w_hit[0] | w_hit[1] | w_hit[2];
            for (int j = 1; j < DLY; j++) begin
                vd_reg[j] <= vd_reg[j-1];
                crd_reg[j] <= crd_reg[j-1];
                wd_reg[j] <= wd_reg[j-1];
                clipd_reg[j] <= clipd_reg[j-1];
            end
        end
    end

    assign v_out = vd_reg[DLY-1];
    assign cr_out = crd_reg[DLY-1];
    assign w_out = wd_reg[DLY-1];
    assign clip_out = clipd_reg[DLY-1];
endmodule
`default_nettype wire
